### rtl/core/waypoint_tracker_core_macros.svh
// Assertion macros used by the waypoint tracker checker.
`ifndef WAYPOINT_TRACKER_CORE_MACROS_SVH
`define WAYPOINT_TRACKER_CORE_MACROS_SVH
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define WT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define WT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/core/wt_pkg.sv
// Types, constants and the arctangent table of the waypoint tracker.
`default_nettype none
package wt_pkg;

	localparam int MAX_POINTS   = 16;
	localparam int COORD_BITS   = 16;
	localparam int CORDIC_STEPS = 16;

	localparam int PT_BITS    = $clog2(MAX_POINTS);
	localparam int CNT_BITS   = PT_BITS + 1;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * COORD_BITS + 1;
	localparam int ROOT_BITS  = SQ_BITS + 1;
	localparam int SQRT_STEPS = (SQ_BITS + 1) / 2;
	localparam int DIV_STEPS  = 31;
	localparam int STEP_BITS  = 5;
	localparam int CX_BITS    = 28;
	localparam int Z_BITS     = 35;
	localparam int CORDIC_SCALE = 8;

	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic signed [Z_BITS-1:0] PI_Q13 = 35'sd25736;
	localparam logic signed [Z_BITS-1:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [Z_BITS-1:0] ROUND_Q17 = 35'sd65536;
	localparam logic [20:0] LEN_MAX   = 21'h1FFFFF;
	localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_POSE  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [1:0] CFG_RADIUS = 2'd0;
	localparam logic [1:0] CFG_COUNT  = 2'd1;
	localparam logic [1:0] CFG_TIME   = 2'd2;

	typedef struct packed {
		op_t                op;
		logic [3:0]         point_index;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic               advance;
	} item_t;

	typedef struct packed {
		logic [16:0]        distance_to_goal;
		logic               at_point;
		logic signed [15:0] heading;
		logic               at_terminal;
		logic [3:0]         goal_number;
		logic               advanced;
		logic [20:0]        path_length_mm;
		logic [23:0]        cruise_speed;
	} result_t;

	typedef struct packed {
		logic                 wr_point;
		logic                 latch_pose;
		logic                 rd_en;
		logic [PT_BITS-1:0]   rd_addr;
		logic                 latch_prev;
		logic                 diff_seg;
		logic                 diff_pose;
		logic                 square;
		logic                 step_sqrt;
		logic                 step_cordic;
		logic                 step_div;
		logic [STEP_BITS-1:0] step;
		logic                 acc_clear;
		logic                 acc_seg;
		logic                 emit;
		logic [3:0]           goal;
		logic                 terminal;
		logic                 advanced;
	} cmd_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] count;
	} stat_t;

	// atan(2^-i) in Q30.
	function automatic logic [29:0] atan_q30(input logic [STEP_BITS-1:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### rtl/core/wt_ctrl.sv
// Controller state machine of the waypoint tracker: sequencing and goal pointer.
`default_nettype none
module wt_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wt_pkg::item_t     item,
	input  wt_pkg::stat_t     stat,
	output logic              busy,
	output wt_pkg::cmd_t      cmd
);
	import wt_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_SEG_RD0  = 12'b0000_0000_0010,
		S_SEG_RD1  = 12'b0000_0000_0100,
		S_SEG_DIF  = 12'b0000_0000_1000,
		S_SEG_SQ   = 12'b0000_0001_0000,
		S_SEG_RUN  = 12'b0000_0010_0000,
		S_SEG_ACC  = 12'b0000_0100_0000,
		S_POSE_RD  = 12'b0000_1000_0000,
		S_POSE_DIF = 12'b0001_0000_0000,
		S_POSE_SQ  = 12'b0010_0000_0000,
		S_POSE_RUN = 12'b0100_0000_0000,
		S_POSE_OUT = 12'b1000_0000_0000
	} state_t;

	state_t               state_q;
	state_t               state_d;
	logic [3:0]           goal_q;
	logic [3:0]           seg_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 adv_q;
	logic                 accept;
	logic                 can_adv;
	logic                 seg_more;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign can_adv  = item.advance && (({1'b0, goal_q} + CNT_BITS'(1)) < stat.count);
	assign seg_more = ({1'b0, seg_q} + CNT_BITS'(1)) < stat.count;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.step = step_q;
		cmd.goal = goal_q;
		cmd.terminal = ({1'b0, goal_q} + CNT_BITS'(1)) >= stat.count;
		cmd.advanced = adv_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (item.op)
						OP_WRITE: cmd.wr_point = 1'b1;
						OP_START: begin
							cmd.acc_clear = 1'b1;
							state_d = S_SEG_RD0;
						end
						OP_POSE: begin
							cmd.latch_pose = 1'b1;
							state_d = S_POSE_RD;
						end
						default: ;
					endcase
				end
			end
			S_SEG_RD0: begin
				cmd.rd_en = 1'b1;
				cmd.rd_addr = seg_q - PT_BITS'(1);
				state_d = S_SEG_RD1;
			end
			S_SEG_RD1: begin
				cmd.latch_prev = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_addr = seg_q;
				state_d = S_SEG_DIF;
			end
			S_SEG_DIF: begin
				cmd.diff_seg = 1'b1;
				state_d = S_SEG_SQ;
			end
			S_SEG_SQ: begin
				cmd.square = 1'b1;
				state_d = S_SEG_RUN;
			end
			S_SEG_RUN: begin
				cmd.step_sqrt = 1'b1;
				if (step_q == STEP_BITS'(SQRT_STEPS - 1)) begin
					state_d = S_SEG_ACC;
				end
			end
			S_SEG_ACC: begin
				cmd.acc_seg = 1'b1;
				state_d = seg_more ? S_SEG_RD0 : S_IDLE;
			end
			S_POSE_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_addr = goal_q;
				state_d = S_POSE_DIF;
			end
			S_POSE_DIF: begin
				cmd.diff_pose = 1'b1;
				state_d = S_POSE_SQ;
			end
			S_POSE_SQ: begin
				cmd.square = 1'b1;
				state_d = S_POSE_RUN;
			end
			S_POSE_RUN: begin
				cmd.step_div = 1'b1;
				cmd.step_sqrt = (step_q < STEP_BITS'(SQRT_STEPS));
				cmd.step_cordic = (step_q < STEP_BITS'(CORDIC_STEPS));
				if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
					state_d = S_POSE_OUT;
				end
			end
			S_POSE_OUT: begin
				cmd.emit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			goal_q <= 4'd1;
			seg_q <= 4'd1;
			step_q <= '0;
			adv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (item.op == OP_START)) begin
				goal_q <= 4'd1;
				seg_q <= 4'd1;
			end
			if (accept && (item.op == OP_POSE)) begin
				adv_q <= can_adv;
				if (can_adv) begin
					goal_q <= goal_q + 4'd1;
				end
			end
			if ((state_q == S_SEG_ACC) && seg_more) begin
				seg_q <= seg_q + 4'd1;
			end
			if ((state_q == S_SEG_RUN) || (state_q == S_POSE_RUN)) begin
				step_q <= step_q + STEP_BITS'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/wt_dpath.sv
// Datapath of the waypoint tracker: waypoint memory, square root, CORDIC and divider.
`default_nettype none
module wt_dpath (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wt_pkg::cmd_t      cmd,
	input  wt_pkg::item_t     item,
	input  wire logic         cfg_valid,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [19:0]  cfg_data,
	output wt_pkg::stat_t     stat,
	output wt_pkg::result_t   result,
	output logic              done
);
	import wt_pkg::*;

	logic [16:0] radius_q;
	logic [4:0]  count_q;
	logic [19:0] time_q;

	logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
	logic [2*COORD_BITS-1:0] rdata_q;

	logic signed [COORD_BITS-1:0] pose_x_q, pose_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0] rd_x, rd_y;
	logic signed [DIFF_BITS-1:0]  dx_q, dy_q, nx, ny;
	logic [COORD_BITS-1:0]        ax, ay;
	logic [2*COORD_BITS-1:0]      ax2, ay2;
	logic [SQ_BITS-1:0]           s_next, s_q, rem_q;
	logic [ROOT_BITS-1:0]         rr_q, root_q, bit_q, trial;
	logic [ROOT_BITS:0]           rounded;

	logic signed [CX_BITS-1:0] cx_q, cy_q, sx, sy;
	logic signed [Z_BITS-1:0]  cz_q, at, hz, hs;
	logic                      zdx_q, dyneg_q;
	logic signed [15:0]        heading;

	logic [30:0] prod, dnum_q, dquo_q;
	logic [19:0] tdiv, drem_q;
	logic [20:0] dshift;

	logic [20:0] length_q;
	logic [21:0] len_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 17'd20;
			count_q <= 5'd2;
			time_q <= 20'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RADIUS: radius_q <= cfg_data[16:0];
				CFG_COUNT:  count_q <= cfg_data[4:0];
				CFG_TIME:   time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (count_q < 5'd2) begin
			stat.count = CNT_BITS'(2);
		end else if (count_q > 5'(MAX_POINTS)) begin
			stat.count = CNT_BITS'(MAX_POINTS);
		end else begin
			stat.count = CNT_BITS'(count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_point) begin
			mem[item.point_index] <= {item.coord_x, item.coord_y};
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[cmd.rd_addr];
		end
	end

	assign rd_x = rdata_q[2*COORD_BITS-1:COORD_BITS];
	assign rd_y = rdata_q[COORD_BITS-1:0];

	assign nx  = -dx_q;
	assign ny  = -dy_q;
	assign ax  = dx_q[DIFF_BITS-1] ? nx[COORD_BITS-1:0] : dx_q[COORD_BITS-1:0];
	assign ay  = dy_q[DIFF_BITS-1] ? ny[COORD_BITS-1:0] : dy_q[COORD_BITS-1:0];
	assign ax2 = ax * ax;
	assign ay2 = ay * ay;
	assign s_next = {1'b0, ax2} + {1'b0, ay2};
	assign prod = length_q * 10'd1000;

	assign trial   = root_q + bit_q;
	assign rounded = ({1'b0, rem_q} > root_q) ? ({1'b0, root_q} + 1'b1) : {1'b0, root_q};

	assign sx = cx_q >>> cmd.step;
	assign sy = cy_q >>> cmd.step;
	assign at = $signed({{(Z_BITS - 30){1'b0}}, atan_q30(cmd.step)});

	assign tdiv   = (time_q == 20'd0) ? 20'd1 : time_q;
	assign dshift = {drem_q, dnum_q[30]};

	assign len_sum = {1'b0, length_q} + 22'(rounded);

	always_ff @(posedge clk) begin
		if (cmd.latch_pose) begin
			pose_x_q <= item.coord_x;
			pose_y_q <= item.coord_y;
		end
		if (cmd.latch_prev) begin
			prev_x_q <= rd_x;
			prev_y_q <= rd_y;
		end
		if (cmd.diff_seg) begin
			dx_q <= DIFF_BITS'(rd_x) - DIFF_BITS'(prev_x_q);
			dy_q <= DIFF_BITS'(rd_y) - DIFF_BITS'(prev_y_q);
		end
		if (cmd.diff_pose) begin
			dx_q <= DIFF_BITS'(rd_x) - DIFF_BITS'(pose_x_q);
			dy_q <= DIFF_BITS'(rd_y) - DIFF_BITS'(pose_y_q);
		end
		if (cmd.square) begin
			s_q <= s_next;
			rem_q <= s_next;
			root_q <= '0;
			bit_q <= ROOT_BITS'(1) << (2 * (SQRT_STEPS - 1));
			rr_q <= radius_q * radius_q;
			dnum_q <= prod;
			drem_q <= '0;
			dquo_q <= '0;
			zdx_q <= (dx_q == '0);
			dyneg_q <= dy_q[DIFF_BITS-1];
			// Poses behind the goal are folded into the right half plane first.
			if (dx_q[DIFF_BITS-1]) begin
				cx_q <= CX_BITS'(nx) <<< CORDIC_SCALE;
				cy_q <= CX_BITS'(ny) <<< CORDIC_SCALE;
				cz_q <= dy_q[DIFF_BITS-1] ? -PI_Q30 : PI_Q30;
			end else begin
				cx_q <= CX_BITS'(dx_q) <<< CORDIC_SCALE;
				cy_q <= CX_BITS'(dy_q) <<< CORDIC_SCALE;
				cz_q <= '0;
			end
		end
		if (cmd.step_sqrt) begin
			if ({1'b0, rem_q} >= trial) begin
				rem_q <= SQ_BITS'({1'b0, rem_q} - trial);
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.step_cordic) begin
			if (!cy_q[CX_BITS-1]) begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				cz_q <= cz_q + at;
			end else begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				cz_q <= cz_q - at;
			end
		end
		if (cmd.step_div) begin
			if (dshift >= {1'b0, tdiv}) begin
				drem_q <= 20'(dshift - {1'b0, tdiv});
				dquo_q <= {dquo_q[29:0], 1'b1};
			end else begin
				drem_q <= dshift[19:0];
				dquo_q <= {dquo_q[29:0], 1'b0};
			end
			dnum_q <= {dnum_q[29:0], 1'b0};
		end
	end

	assign hz = cz_q + ROUND_Q17;
	assign hs = hz >>> 17;

	always_comb begin
		if (zdx_q) begin
			heading = dyneg_q ? -HALF_PI_Q13 : HALF_PI_Q13;
		end else if (hs > PI_Q13) begin
			heading = 16'(PI_Q13);
		end else if (hs < -PI_Q13) begin
			heading = 16'(-PI_Q13);
		end else begin
			heading = 16'(hs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (cmd.acc_clear) begin
			length_q <= '0;
		end else if (cmd.acc_seg) begin
			length_q <= (len_sum > {1'b0, LEN_MAX}) ? LEN_MAX : len_sum[20:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result.distance_to_goal <= rounded[16:0];
			result.at_point <= ({1'b0, s_q} <= rr_q);
			result.heading <= heading;
			result.at_terminal <= cmd.terminal;
			result.goal_number <= cmd.goal;
			result.advanced <= cmd.advanced;
			result.path_length_mm <= length_q;
			result.cruise_speed <= (dquo_q > 31'(SPEED_MAX)) ? SPEED_MAX : dquo_q[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

endmodule
`default_nettype wire

### rtl/core/waypoint_tracker_core.sv
// Top level of the waypoint tracker: controller and datapath.
//
//  channel   signals                                  transaction
//  command   start, busy, item                        start high while busy low
//  result    done, result                             done high, one cycle
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid and cfg_ready high
//
// A waypoint write leaves busy low. For each segment, a path start runs the
// 17-step shared square-root unit. A pose update raises busy while the 31-step
// divider runs beside the square root and the CORDIC; done is registered from
// the last busy state and rises as busy falls. Reset idles the controller,
// loads config defaults, sets the goal pointer to one, clears the length.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module waypoint_tracker_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wt_pkg::item_t     item,
	output logic              done,
	output wt_pkg::result_t   result,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [19:0]  cfg_data
);
	import wt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	wt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	wt_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.result    (result),
		.done      (done)
	);

endmodule
`default_nettype wire

### rtl/core/wt_checker.sv
// Port-level checker of the waypoint tracker and its bind to the top level.
`default_nettype none
`include "waypoint_tracker_core_macros.svh"
module wt_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         start,
	input wire logic         busy,
	input wt_pkg::item_t     item,
	input wire logic         done,
	input wt_pkg::result_t   result
);
	import wt_pkg::*;

	`WT_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
	`WT_ASSERT_NEXT(a_no_result_other_ops, start && !busy && (item.op != OP_POSE), !done, "result from an operation that gives none")
	`WT_ASSERT_NEXT(a_pose_goes_busy, start && !busy && (item.op == OP_POSE), busy, "pose update did not raise busy")
	`WT_ASSERT_NOW(a_heading_range, done, (result.heading <= 16'sd25736) && (result.heading >= -16'sd25736), "heading out of range")

endmodule

bind waypoint_tracker_core wt_checker u_wt_checker (.*);
`default_nettype wire
